// File: hw/rtl/dikv_pkg.sv
package dikv_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_BITS  = 32;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int WORD_W      = VALUE_BITS + 1;
  localparam int CMD_W       = 3;
  localparam int KEY_W       = 12;
  localparam int FIELD_W     = 32;
  localparam int COUNT_W     = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CMD_W-1:0]      cmd_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [KEY_W:0]        key_ext_t;
  typedef logic [FIELD_W-1:0]    field_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [COUNT_W-1:0]    count_t;

  localparam cmd_t CMD_PUT    = 3'd0;
  localparam cmd_t CMD_GET    = 3'd1;
  localparam cmd_t CMD_REMOVE = 3'd2;
  localparam cmd_t CMD_FIND   = 3'd3;
  localparam cmd_t CMD_CLEAR  = 3'd4;

  localparam addr_t    LAST_ADDR = addr_t'(CAPACITY - 1);
  localparam key_ext_t KEY_LIMIT = key_ext_t'(CAPACITY);

  typedef enum logic [2:0] {
    OP_PUT,
    OP_GET,
    OP_REMOVE,
    OP_FIND,
    OP_CLEAR,
    OP_NOP,
    OP_KEYERR
  } op_t;

  typedef struct packed {
    op_t    op;
    addr_t  addr;
    value_t value;
  } job_t;

  typedef enum logic [1:0] {
    ST_WIPE,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN
  } state_t;

  function automatic op_t classify(input cmd_t cmd, input key_t key);
    logic in_range;
    op_t  op;
    in_range = ({1'b0, key} < KEY_LIMIT);
    case (cmd)
      CMD_PUT:    op = in_range ? OP_PUT : OP_KEYERR;
      CMD_GET:    op = in_range ? OP_GET : OP_KEYERR;
      CMD_REMOVE: op = in_range ? OP_REMOVE : OP_KEYERR;
      CMD_FIND:   op = OP_FIND;
      CMD_CLEAR:  op = OP_CLEAR;
      default:    op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

// File: hw/rtl/dikv_if.sv
interface dikv_req_if;
  logic                 valid;
  logic                 ready;
  dikv_pkg::cmd_t       command;
  dikv_pkg::key_t       key;
  dikv_pkg::field_t     value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

interface dikv_rsp_if;
  logic                 valid;
  logic                 ready;
  dikv_pkg::field_t     old_or_read_value;
  logic                 found;
  logic                 key_error;
  dikv_pkg::count_t     entry_count;

  modport source (output valid, old_or_read_value, found, key_error, entry_count, input ready);
  modport sink   (input valid, old_or_read_value, found, key_error, entry_count, output ready);
endinterface

// File: hw/rtl/dikv_ram.sv
module dikv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/dikv_front.sv
module dikv_front (
  input  logic           clk,
  input  logic           rst,
  dikv_req_if.sink       req,
  output dikv_pkg::job_t head,
  output logic           head_valid,
  input  logic           pop
);

  dikv_pkg::job_t                     slots [dikv_pkg::QUEUE_DEPTH];
  logic [dikv_pkg::QPTR_W-1:0]        wr_ptr;
  logic [dikv_pkg::QPTR_W-1:0]        rd_ptr;
  logic [dikv_pkg::QFILL_W-1:0]       fill;
  logic                               push;
  logic                               take;
  dikv_pkg::job_t                     incoming;

  assign req.ready  = (fill != dikv_pkg::QFILL_W'(dikv_pkg::QUEUE_DEPTH));
  assign push       = req.valid && req.ready;
  assign head_valid = (fill != '0);
  assign take       = pop && head_valid;
  assign head       = slots[rd_ptr];

  // The command is decoded here, so the back end never looks at raw keys.
  always_comb begin
    incoming.op    = dikv_pkg::classify(req.command, req.key);
    incoming.addr  = req.key[dikv_pkg::ADDR_W-1:0];
    incoming.value = dikv_pkg::value_t'(req.value);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !take) begin
        fill <= fill + 1'b1;
      end else if (take && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/dikv_back.sv
module dikv_back (
  input  logic           clk,
  input  logic           rst,
  input  dikv_pkg::job_t head,
  input  logic           head_valid,
  output logic           pop,
  dikv_rsp_if.source     rsp
);

  dikv_pkg::state_t state, state_next;
  dikv_pkg::job_t   job, job_next;
  dikv_pkg::count_t valid_count, valid_count_next;
  dikv_pkg::addr_t  wipe_addr, wipe_addr_next;
  logic             wipe_report, wipe_report_next;
  dikv_pkg::addr_t  scan_addr, scan_addr_next;

  logic             out_valid;
  dikv_pkg::field_t out_value;
  logic             out_found;
  logic             out_kerr;
  dikv_pkg::count_t out_count;

  logic             res_load;
  dikv_pkg::value_t res_value;
  logic             res_found;
  logic             res_kerr;
  dikv_pkg::count_t res_count;

  logic             ram_we;
  dikv_pkg::addr_t  ram_waddr;
  dikv_pkg::word_t  ram_wdata;
  dikv_pkg::addr_t  ram_raddr;
  dikv_pkg::word_t  ram_rdata;

  logic             out_free;
  logic             hit;
  dikv_pkg::value_t stored;
  logic             match;

  // Each word holds the valid flag above the value.
  dikv_ram #(
    .WIDTH (dikv_pkg::WORD_W),
    .DEPTH (dikv_pkg::CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || rsp.ready;
  assign hit      = ram_rdata[dikv_pkg::VALUE_BITS];
  assign stored   = ram_rdata[dikv_pkg::VALUE_BITS-1:0];
  assign match    = hit && (stored == job.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dikv_pkg::ST_WIPE;
      valid_count <= '0;
      wipe_addr   <= '0;
      wipe_report <= 1'b0;
    end else begin
      state       <= state_next;
      valid_count <= valid_count_next;
      wipe_addr   <= wipe_addr_next;
      wipe_report <= wipe_report_next;
    end
  end

  always_ff @(posedge clk) begin
    job       <= job_next;
    scan_addr <= scan_addr_next;
  end

  always_comb begin
    state_next       = state;
    job_next         = job;
    valid_count_next = valid_count;
    wipe_addr_next   = wipe_addr;
    wipe_report_next = wipe_report;
    scan_addr_next   = scan_addr;
    pop              = 1'b0;
    res_load         = 1'b0;
    res_value        = '0;
    res_found        = 1'b0;
    res_kerr         = 1'b0;
    res_count        = valid_count;
    ram_we           = 1'b0;
    ram_waddr        = job.addr;
    ram_wdata        = '0;
    ram_raddr        = head.addr;

    case (state)
      dikv_pkg::ST_WIPE: begin
        ram_we    = 1'b1;
        ram_waddr = wipe_addr;
        ram_wdata = '0;
        if (wipe_addr == dikv_pkg::LAST_ADDR) begin
          state_next       = dikv_pkg::ST_IDLE;
          valid_count_next = '0;
          wipe_report_next = 1'b0;
          // The pass after reset answers nothing; a clear command answers here.
          res_load         = wipe_report;
          res_count        = '0;
        end else begin
          wipe_addr_next = wipe_addr + 1'b1;
        end
      end

      dikv_pkg::ST_IDLE: begin
        if (head_valid && out_free) begin
          pop      = 1'b1;
          job_next = head;
          case (head.op)
            dikv_pkg::OP_PUT, dikv_pkg::OP_GET, dikv_pkg::OP_REMOVE: begin
              ram_raddr  = head.addr;
              state_next = dikv_pkg::ST_ACCESS;
            end
            dikv_pkg::OP_FIND: begin
              ram_raddr      = '0;
              scan_addr_next = '0;
              state_next     = dikv_pkg::ST_SCAN;
            end
            dikv_pkg::OP_CLEAR: begin
              wipe_addr_next   = '0;
              wipe_report_next = 1'b1;
              state_next       = dikv_pkg::ST_WIPE;
            end
            dikv_pkg::OP_KEYERR: begin
              res_load = 1'b1;
              res_kerr = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      dikv_pkg::ST_ACCESS: begin
        res_load   = 1'b1;
        res_found  = hit;
        res_value  = hit ? stored : '0;
        ram_waddr  = job.addr;
        state_next = dikv_pkg::ST_IDLE;
        if (job.op == dikv_pkg::OP_PUT) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, job.value};
          if (!hit) begin
            valid_count_next = valid_count + 1'b1;
          end
        end else if (job.op == dikv_pkg::OP_REMOVE && hit) begin
          ram_we           = 1'b1;
          ram_wdata        = {1'b0, stored};
          valid_count_next = valid_count - 1'b1;
        end
        res_count = valid_count_next;
      end

      dikv_pkg::ST_SCAN: begin
        // Read data always belongs to scan_addr; the next address is issued meanwhile.
        if (match || scan_addr == dikv_pkg::LAST_ADDR) begin
          res_load   = 1'b1;
          res_found  = match;
          state_next = dikv_pkg::ST_IDLE;
        end else begin
          ram_raddr      = scan_addr + 1'b1;
          scan_addr_next = scan_addr + 1'b1;
        end
      end

      default: begin
        state_next = dikv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_value <= dikv_pkg::field_t'(res_value);
      out_found <= res_found;
      out_kerr  <= res_kerr;
      out_count <= res_count;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.old_or_read_value = out_value;
  assign rsp.found             = out_found;
  assign rsp.key_error         = out_kerr;
  assign rsp.entry_count       = out_count;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= dikv_pkg::count_t'(dikv_pkg::CAPACITY))
    else $error("valid entry count exceeds the table size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || rsp.ready))
    else $error("result loaded over an untaken transaction");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state != dikv_pkg::ST_IDLE) |-> !pop)
    else $error("queue popped while a command is in progress");

  a_wipe_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> (state == dikv_pkg::ST_WIPE && !wipe_report))
    else $error("table not swept after reset");

  a_access_follows_pop: assert property (@(posedge clk) disable iff (rst)
    (state == dikv_pkg::ST_ACCESS) |-> $past(pop))
    else $error("table access without a dequeued command");
`endif

endmodule

// File: hw/rtl/direct_indexed_key_value_table.sv
// Channel  Role  Payload
// req      sink  command, key, value
// rsp      src   old_or_read_value, found, key_error, entry_count
//
// Put, get and remove read the table when dequeued, then write back and answer
// from the access state. Key errors and unknown commands answer in the cycle after dequeue.
// Find_value reads one entry per cycle until a match or the last entry, and
// clear holds the back end, rewriting one entry per cycle.
// After reset the table is swept entry by entry before the first command
// runs; requests are still queued (two deep) meanwhile.
// A stalled response holds the back end, while the queue keeps taking requests until full.
module direct_indexed_key_value_table (
  input  logic       clk,
  input  logic       rst,
  dikv_req_if.sink   req,
  dikv_rsp_if.source rsp
);

  dikv_pkg::job_t head;
  logic           head_valid;
  logic           pop;

  dikv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  dikv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
